// ===== src/nprm_pkg.sv =====
// Shared types and constants of the NAPOT protection region manager.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps

package nprm_pkg;

	localparam int unsigned WORD_W     = 64;
	localparam int unsigned ORDER_W    = 7;
	localparam int unsigned PERM_W     = 3;
	localparam int unsigned INDEX_W    = 4;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned LOCK_W     = 16;
	localparam int unsigned LOCK_IDX_W = 4;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [COUNT_W-1:0] ENTRIES_RESET = 5'd16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKED_ENTRIES = 1'b1;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_DENIED    = 3'd2,
		ST_NO_SPACE  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_END,
		S_ORDER,
		S_CHECK,
		S_SCAN,
		S_RESOLVE,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t               opcode;
		logic [WORD_W-1:0] region_addr;
		logic [WORD_W-1:0] region_len;
		logic [WORD_W-1:0] perm_request;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] entry_index;
		logic [PERM_W-1:0]  perm_result;
	} rsp_t;

	// Number of significant bits in a byte (0 for zero)
	function automatic logic [3:0] bit_len8(input logic [7:0] v);
		logic [3:0] len;
		len = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) begin
				len = 4'(i + 1);
			end
		end
		return len;
	endfunction

endpackage

// ===== src/nprm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nprm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/napot_protection_region_manager.sv =====
// Top level of the NAPOT protection region manager: sequencer, shared adder,
// order search, entry scan and configuration registers.
// Depends on nprm_pkg and nprm_ram.
`timescale 1ns / 1ps

// One set or get request is handled at a time; req_stall stays high from
// acceptance until the response has been loaded into the output register.
// A request is rejected once its size and permission bits are checked, or
// once its window is checked; otherwise it goes on through the order search,
// one step per byte of region_len - 1, and then the entry scan, one read per
// entry from the registered-output entry RAM, ending early on a match. A
// stalled earlier response must leave the output register before the next
// response is loaded. A 64-bit adder is shared between the size and end
// computations, and the entry RAM has a single read port.
// Entry flags clear at reset, so no clearing pass is needed. The response
// waits in an output register; the next request may be accepted while it is
// still stalled.
module napot_protection_region_manager #(
	parameter int unsigned MAX_ENTRIES = 16,
	parameter int unsigned ADDR_WIDTH  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  nprm_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output nprm_pkg::rsp_t                   rsp,
	input  logic                             cfg_we,
	input  logic [nprm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nprm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned ENT_W  = ADDR_WIDTH + nprm_pkg::ORDER_W + nprm_pkg::PERM_W;
	localparam logic [nprm_pkg::WORD_W-1:0] ADDR_MASK = (ADDR_WIDTH >= 64) ? '1 :
		((64'd1 << ADDR_WIDTH) - 64'd1);

	nprm_pkg::state_t state_q, state_d;

	// Configuration
	logic [nprm_pkg::COUNT_W-1:0] entries_q;
	logic [nprm_pkg::LOCK_W-1:0]  locked_q;
	logic [CNT_W-1:0]             n_entries;

	// Request and normalization
	nprm_pkg::req_t                 req_q;
	logic [nprm_pkg::WORD_W-1:0]    addr_m;
	logic [nprm_pkg::WORD_W-1:0]    add_a, add_b;
	logic [nprm_pkg::WORD_W:0]      add_sum;
	logic [nprm_pkg::WORD_W-1:0]    sh_q;
	logic [nprm_pkg::WORD_W-1:0]    end_q;
	logic                           wrap_q;
	logic [nprm_pkg::ORDER_W-1:0]   k_q, k_eff;
	logic [nprm_pkg::WORD_W-1:0]    win_mask;
	logic                           ck_full, ck_bad;
	logic                           dec_bad;
	logic [ADDR_WIDTH-1:0]          base_q;
	logic [nprm_pkg::ORDER_W-1:0]   order_q;

	// Scan
	logic [MAX_ENTRIES-1:0]         active_q;
	logic [CNT_W-1:0]               issue_q;
	logic                           pend_s1;
	logic [IDX_W-1:0]               pend_idx_s1;
	logic                           free_found_q;
	logic [IDX_W-1:0]               free_idx_q;
	logic                           hit_q;
	logic [IDX_W-1:0]               hit_idx_q;
	logic [nprm_pkg::PERM_W-1:0]    hit_perm_q;
	logic                           hit_now;
	logic                           issue_more;
	logic                           locked_hit;

	// Entry RAM
	logic                           ram_we, ram_re;
	logic [IDX_W-1:0]               ram_waddr;
	logic [ENT_W-1:0]               ram_wdata, ram_rdata;
	logic [ADDR_WIDTH-1:0]          rd_base;
	logic [nprm_pkg::ORDER_W-1:0]   rd_order;
	logic [nprm_pkg::PERM_W-1:0]    rd_perm;

	// Result
	nprm_pkg::rsp_t                 res_d, res_q, rsp_q;
	logic                           res_load, rsp_load;
	logic                           rsp_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= nprm_pkg::ENTRIES_RESET;
			locked_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				nprm_pkg::CFG_ENTRIES_IN_USE: entries_q <= cfg_wdata[nprm_pkg::COUNT_W-1:0];
				nprm_pkg::CFG_LOCKED_ENTRIES: locked_q  <= cfg_wdata[nprm_pkg::LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate the scan length at the implemented entry count
	always_comb begin
		if (7'(entries_q) > 7'(MAX_ENTRIES)) begin
			n_entries = CNT_W'(MAX_ENTRIES);
		end else begin
			n_entries = CNT_W'(entries_q);
		end
	end

	assign addr_m = req_q.region_addr & ADDR_MASK;

	// Shared adder: size - 1 first, then addr + (size - 1)
	always_comb begin
		if (state_q == nprm_pkg::S_DEC) begin
			add_a = req_q.region_len;
			add_b = '1;
		end else begin
			add_a = addr_m;
			add_b = sh_q;
		end
	end
	assign add_sum = {1'b0, add_a} + {1'b0, add_b};

	// Carry clear means size was zero
	assign dec_bad = !add_sum[nprm_pkg::WORD_W] ||
		(req_q.opcode == nprm_pkg::OP_SET &&
		 (|req_q.perm_request[nprm_pkg::WORD_W-1:nprm_pkg::PERM_W]));

	// Window checks
	assign k_eff = (k_q < 7'd2) ? 7'd2 : k_q;
	always_comb begin
		for (int j = 0; j < nprm_pkg::WORD_W; j++) begin
			win_mask[j] = (7'(j) < k_eff);
		end
	end
	assign ck_full = (k_eff == 7'(ADDR_WIDTH));
	assign ck_bad  = (k_eff > 7'(ADDR_WIDTH)) ||
		(!ck_full && (wrap_q || (|(end_q & ~ADDR_MASK)) ||
		              (|((end_q ^ addr_m) & ~win_mask))));

	// Entry RAM word: {base, order, perm}
	assign rd_perm  = ram_rdata[nprm_pkg::PERM_W-1:0];
	assign rd_order = ram_rdata[nprm_pkg::PERM_W +: nprm_pkg::ORDER_W];
	assign rd_base  = ram_rdata[nprm_pkg::PERM_W + nprm_pkg::ORDER_W +: ADDR_WIDTH];
	assign ram_wdata = {base_q, order_q, req_q.perm_request[nprm_pkg::PERM_W-1:0]};

	assign issue_more = (issue_q < n_entries);
	assign hit_now = pend_s1 && active_q[pend_idx_s1] &&
		(rd_base == base_q) && (rd_order == order_q);
	assign locked_hit = (7'(hit_idx_q) < 7'(nprm_pkg::LOCK_W)) &&
		locked_q[nprm_pkg::LOCK_IDX_W'(hit_idx_q)];

	nprm_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(issue_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nprm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		res_load  = 1'b0;
		rsp_load  = 1'b0;
		res_d     = '{status: nprm_pkg::ST_OK, entry_index: '0, perm_result: '0};
		case (state_q)
			nprm_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = nprm_pkg::S_DEC;
				end
			end
			nprm_pkg::S_DEC: begin
				if (dec_bad) begin
					res_load     = 1'b1;
					res_d.status = nprm_pkg::ST_INVALID;
					state_d      = nprm_pkg::S_DONE;
				end else begin
					state_d = nprm_pkg::S_END;
				end
			end
			nprm_pkg::S_END: begin
				state_d = nprm_pkg::S_ORDER;
			end
			nprm_pkg::S_ORDER: begin
				if (sh_q[nprm_pkg::WORD_W-1:8] == '0) begin
					state_d = nprm_pkg::S_CHECK;
				end
			end
			nprm_pkg::S_CHECK: begin
				if (ck_bad) begin
					res_load     = 1'b1;
					res_d.status = nprm_pkg::ST_INVALID;
					state_d      = nprm_pkg::S_DONE;
				end else begin
					state_d = nprm_pkg::S_SCAN;
				end
			end
			nprm_pkg::S_SCAN: begin
				ram_re = issue_more;
				// Stop on a match, or once the last read has been examined
				if (hit_now || (!pend_s1 && !issue_more)) begin
					state_d = nprm_pkg::S_RESOLVE;
				end
			end
			nprm_pkg::S_RESOLVE: begin
				res_load = 1'b1;
				state_d  = nprm_pkg::S_DONE;
				if (req_q.opcode == nprm_pkg::OP_GET) begin
					if (hit_q) begin
						res_d.entry_index = nprm_pkg::INDEX_W'(hit_idx_q);
						res_d.perm_result = hit_perm_q;
					end else begin
						res_d.status = nprm_pkg::ST_NOT_FOUND;
					end
				end else if (hit_q) begin
					if (locked_hit) begin
						res_d.status = nprm_pkg::ST_DENIED;
					end else begin
						ram_we            = 1'b1;
						ram_waddr         = hit_idx_q;
						res_d.entry_index = nprm_pkg::INDEX_W'(hit_idx_q);
					end
				end else if (free_found_q) begin
					ram_we            = 1'b1;
					ram_waddr         = free_idx_q;
					res_d.entry_index = nprm_pkg::INDEX_W'(free_idx_q);
				end else begin
					res_d.status = nprm_pkg::ST_NO_SPACE;
				end
			end
			nprm_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = nprm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nprm_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				active_q[ram_waddr] <= 1'b1;
			end
			pend_s1 <= ram_re;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			nprm_pkg::S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			nprm_pkg::S_DEC: begin
				sh_q <= add_sum[nprm_pkg::WORD_W-1:0];
				k_q  <= '0;
			end
			nprm_pkg::S_END: begin
				end_q  <= add_sum[nprm_pkg::WORD_W-1:0];
				wrap_q <= add_sum[nprm_pkg::WORD_W];
			end
			nprm_pkg::S_ORDER: begin
				// Advance one byte per cycle, finish with the top byte's length
				if (sh_q[nprm_pkg::WORD_W-1:8] != '0) begin
					sh_q <= sh_q >> 8;
					k_q  <= k_q + 7'd8;
				end else begin
					k_q <= k_q + 7'(nprm_pkg::bit_len8(sh_q[7:0]));
				end
			end
			nprm_pkg::S_CHECK: begin
				base_q       <= ck_full ? '0 : ADDR_WIDTH'(addr_m & ~win_mask);
				order_q      <= k_eff;
				issue_q      <= '0;
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
			end
			nprm_pkg::S_SCAN: begin
				if (ram_re) begin
					issue_q     <= issue_q + CNT_W'(1);
					pend_idx_s1 <= issue_q[IDX_W-1:0];
				end
				if (pend_s1 && !active_q[pend_idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= pend_idx_s1;
				end
				if (hit_now) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= pend_idx_s1;
					hit_perm_q <= rd_perm;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != nprm_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_hit_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nprm_pkg::S_RESOLVE && hit_q) |-> active_q[hit_idx_q])
		else $error("matched entry is not active");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nprm_pkg::S_RESOLVE && hit_q) |-> (7'(hit_idx_q) < 7'(n_entries)))
		else $error("matched entry lies beyond the scan length");

	a_free_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nprm_pkg::S_RESOLVE && free_found_q) |-> !active_q[free_idx_q])
		else $error("free entry chosen for fill is active");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == nprm_pkg::S_DONE))
		else $error("response raised outside the done state");
`endif

endmodule
